// ===== hw/rtl/buddy_block_allocator_defines.svh =====
// assertion macros used by the buddy block allocator datapath
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define BBA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds in a cycle, consequent must hold in the next cycle
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bba_pkg.sv =====
// types, constants and control structs of the buddy block allocator
package bba_pkg;

  localparam int POOL_UNITS = 1024;
  localparam int MIN_BLOCK  = 32;
  localparam int LEAF_COUNT = POOL_UNITS / MIN_BLOCK;
  localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;
  localparam int MAX_LVL    = $clog2(LEAF_COUNT);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LVL_W      = $clog2(MAX_LVL + 1);
  localparam int OFF_W      = $clog2(POOL_UNITS);
  localparam int SIZE_W     = OFF_W + 1;

  typedef enum logic [1:0] {
    NS_ABSENT = 2'd0,
    NS_FREE   = 2'd1,
    NS_ALLOC  = 2'd2,
    NS_SPLIT  = 2'd3
  } node_st_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOBLOCK = 2'd2
  } res_status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_A_READ,
    S_A_EVAL,
    S_A_BACK,
    S_A_SPL_L,
    S_A_SPL_R,
    S_F_READ,
    S_F_EVAL,
    S_M_READ,
    S_M_EVAL,
    S_M_W_SIB,
    S_M_W_PAR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    NAV_HOLD,
    NAV_LOAD,
    NAV_LEFT,
    NAV_BY_OFF,
    NAV_RIGHT_SIB,
    NAV_PARENT
  } nav_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_OK,
    RES_NOFIT,
    RES_NOBLOCK
  } res_e;

  typedef enum logic [2:0] {
    SEL_NODE,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_SIB,
    SEL_PARENT
  } sel_e;

  typedef struct packed {
    nav_e     nav;
    res_e     res;
    logic     rd_en;
    sel_e     rd_sel;
    logic     wr_en;
    sel_e     wr_sel;
    node_st_e wr_val;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    node_st_e st;
    logic     fits;
    logic     at_min;
    logic     is_root;
    logic     is_left;
    logic     oversize;
    action_e  action;
    logic     match;
    logic     out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bba_ctrl.sv =====
// sequencer of the buddy block allocator: search, split, free and merge walks
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t cmd_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.action == ACT_FREE) state_d = S_F_EVAL;
        else if (sts_i.oversize)      state_d = S_DONE;
        else                          state_d = S_A_EVAL;
      end
      S_A_READ: state_d = S_A_EVAL;
      S_A_EVAL: begin
        case (sts_i.st)
          NS_FREE:  state_d = sts_i.fits ? S_A_SPL_L : S_DONE;
          NS_SPLIT: state_d = sts_i.fits ? S_A_READ : S_A_BACK;
          default:  state_d = S_A_BACK;
        endcase
      end
      S_A_BACK: begin
        if (sts_i.is_root)      state_d = S_DONE;
        else if (sts_i.is_left) state_d = S_A_READ;
      end
      S_A_SPL_L: state_d = S_A_SPL_R;
      S_A_SPL_R: state_d = S_A_READ;
      S_F_READ:  state_d = S_F_EVAL;
      S_F_EVAL: begin
        if (sts_i.st == NS_SPLIT && !sts_i.at_min)      state_d = S_F_READ;
        else if (sts_i.st == NS_ALLOC && sts_i.match)   state_d = S_M_READ;
        else                                            state_d = S_DONE;
      end
      S_M_READ:  state_d = sts_i.is_root ? S_DONE : S_M_EVAL;
      S_M_EVAL:  state_d = (sts_i.st == NS_FREE) ? S_M_W_SIB : S_DONE;
      S_M_W_SIB: state_d = S_M_W_PAR;
      S_M_W_PAR: state_d = S_M_READ;
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.nav      = NAV_HOLD;
    cmd_o.res      = RES_HOLD;
    cmd_o.rd_sel   = SEL_NODE;
    cmd_o.wr_sel   = SEL_NODE;
    cmd_o.wr_val   = NS_ABSENT;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.nav = NAV_LOAD;
      end
      S_CHECK: begin
        if (sts_i.action == ACT_ALLOC && sts_i.oversize) begin
          cmd_o.res = RES_NOFIT;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_A_READ: cmd_o.rd_en = 1'b1;
      S_A_EVAL: begin
        case (sts_i.st)
          NS_FREE: begin
            cmd_o.wr_en = 1'b1;
            if (sts_i.fits) begin
              cmd_o.wr_val = NS_SPLIT;
            end else begin
              cmd_o.wr_val = NS_ALLOC;
              cmd_o.res    = RES_OK;
            end
          end
          NS_SPLIT: begin
            if (sts_i.fits) cmd_o.nav = NAV_LEFT;
          end
          default: ;
        endcase
      end
      S_A_BACK: begin
        if (sts_i.is_root)      cmd_o.res = RES_NOFIT;
        else if (sts_i.is_left) cmd_o.nav = NAV_RIGHT_SIB;
        else                    cmd_o.nav = NAV_PARENT;
      end
      S_A_SPL_L: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = SEL_LEFT;
        cmd_o.wr_val = NS_FREE;
      end
      S_A_SPL_R: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = SEL_RIGHT;
        cmd_o.wr_val = NS_FREE;
        cmd_o.nav    = NAV_LEFT;
      end
      S_F_READ: cmd_o.rd_en = 1'b1;
      S_F_EVAL: begin
        if (sts_i.st == NS_SPLIT && !sts_i.at_min) begin
          cmd_o.nav = NAV_BY_OFF;
        end else if (sts_i.st == NS_ALLOC && sts_i.match) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_val = NS_FREE;
          cmd_o.res    = RES_OK;
        end else begin
          cmd_o.res = RES_NOBLOCK;
        end
      end
      S_M_READ: begin
        if (!sts_i.is_root) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = SEL_SIB;
        end
      end
      S_M_EVAL: begin
        if (sts_i.st == NS_FREE) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_val = NS_ABSENT;
        end
      end
      S_M_W_SIB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = SEL_SIB;
        cmd_o.wr_val = NS_ABSENT;
      end
      S_M_W_PAR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = SEL_PARENT;
        cmd_o.wr_val = NS_FREE;
        cmd_o.nav    = NAV_PARENT;
      end
      S_DONE: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/bba_dp.sv =====
// datapath of the buddy block allocator: node state memory, walk registers, result
module bba_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   action_i,
  input  logic [10:0]            request_size_i,
  input  logic [9:0]             free_offset_i,
  input  bba_pkg::cmd_t          cmd_i,
  output bba_pkg::sts_t          sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [9:0]             block_offset_o,
  output logic [10:0]            block_size_o
);
  import bba_pkg::*;
  `include "buddy_block_allocator_defines.svh"

  localparam logic [SIZE_W-1:0] POOL_SIZE = SIZE_W'(POOL_UNITS);

  // node state memory, entries not yet written read as their reset state
  node_st_e              mem_q [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_q;
  node_st_e              rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_root_q;

  action_e           action_q;
  logic [SIZE_W-1:0] req_q;
  logic [OFF_W-1:0]  foff_q;
  logic [NODE_W-1:0] node_q, node_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [OFF_W-1:0]  start_q, start_d;

  res_status_e       res_st_q;
  logic [OFF_W-1:0]  res_off_q;
  logic [SIZE_W-1:0] res_size_q;

  logic              out_valid_q;
  res_status_e       out_st_q;
  logic [OFF_W-1:0]  out_off_q;
  logic [SIZE_W-1:0] out_size_q;

  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] half;
  logic [NODE_W-1:0] left_n, right_n, sib_n, parent_n;
  logic [NODE_W-1:0] raddr, waddr;
  logic [SIZE_W-1:0] mid;
  logic              go_right;
  node_st_e          rd_st;

  assign size     = POOL_SIZE >> lvl_q;
  assign half     = size >> 1;
  assign left_n   = NODE_W'({node_q, 1'b1});
  assign right_n  = left_n + NODE_W'(1);
  assign sib_n    = node_q[0] ? node_q + NODE_W'(1) : node_q - NODE_W'(1);
  assign parent_n = (node_q - NODE_W'(1)) >> 1;
  assign mid      = {1'b0, start_q} + half;
  assign go_right = {1'b0, foff_q} >= mid;

  function automatic logic [NODE_W-1:0] pick(sel_e sel, logic [NODE_W-1:0] n,
                                             logic [NODE_W-1:0] l, logic [NODE_W-1:0] r,
                                             logic [NODE_W-1:0] s, logic [NODE_W-1:0] p);
    logic [NODE_W-1:0] a;
    case (sel)
      SEL_LEFT:   a = l;
      SEL_RIGHT:  a = r;
      SEL_SIB:    a = s;
      SEL_PARENT: a = p;
      default:    a = n;
    endcase
    return a;
  endfunction

  assign raddr = pick(cmd_i.rd_sel, node_q, left_n, right_n, sib_n, parent_n);
  assign waddr = pick(cmd_i.wr_sel, node_q, left_n, right_n, sib_n, parent_n);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= cmd_i.wr_val;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[raddr];
      rd_vld_q  <= vld_q[raddr];
      rd_root_q <= (raddr == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.wr_en) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  assign rd_st = rd_vld_q ? rd_data_q : (rd_root_q ? NS_FREE : NS_ABSENT);

  // walk position
  always_comb begin
    node_d  = node_q;
    lvl_d   = lvl_q;
    start_d = start_q;
    case (cmd_i.nav)
      NAV_LOAD: begin
        node_d  = '0;
        lvl_d   = '0;
        start_d = '0;
      end
      NAV_LEFT: begin
        node_d = left_n;
        lvl_d  = lvl_q + LVL_W'(1);
      end
      NAV_BY_OFF: begin
        lvl_d = lvl_q + LVL_W'(1);
        if (go_right) begin
          node_d  = right_n;
          start_d = mid[OFF_W-1:0];
        end else begin
          node_d = left_n;
        end
      end
      NAV_RIGHT_SIB: begin
        node_d  = node_q + NODE_W'(1);
        start_d = start_q + size[OFF_W-1:0];
      end
      NAV_PARENT: begin
        node_d = parent_n;
        lvl_d  = lvl_q - LVL_W'(1);
        if (!node_q[0]) start_d = start_q - size[OFF_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    lvl_q   <= lvl_d;
    start_q <= start_d;
    if (cmd_i.nav == NAV_LOAD) begin
      action_q <= action_e'(action_i);
      req_q    <= (request_size_i == '0) ? SIZE_W'(1) : request_size_i;
      foff_q   <= free_offset_i;
    end
    case (cmd_i.res)
      RES_OK: begin
        res_st_q   <= ST_DONE;
        res_off_q  <= start_q;
        res_size_q <= size;
      end
      RES_NOFIT: begin
        res_st_q   <= ST_NOFIT;
        res_off_q  <= '0;
        res_size_q <= '0;
      end
      RES_NOBLOCK: begin
        res_st_q   <= ST_NOBLOCK;
        res_off_q  <= '0;
        res_size_q <= '0;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_st_q   <= res_st_q;
      out_off_q  <= res_off_q;
      out_size_q <= res_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.st       = rd_st;
  assign sts_o.fits     = (half >= req_q) && (lvl_q != LVL_W'(MAX_LVL));
  assign sts_o.at_min   = (lvl_q == LVL_W'(MAX_LVL));
  assign sts_o.is_root  = (node_q == '0);
  assign sts_o.is_left  = node_q[0];
  assign sts_o.oversize = (req_q > POOL_SIZE);
  assign sts_o.action   = action_q;
  assign sts_o.match    = (start_q == foff_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign block_offset_o = out_off_q;
  assign block_size_o   = out_size_q;

  `BBA_ASSERT_IMPLIES(a_ok_size_pow2, out_valid_q && out_st_q == ST_DONE, $onehot(out_size_q))
  `BBA_ASSERT_IMPLIES(a_ok_aligned, out_valid_q && out_st_q == ST_DONE,
                      ({1'b0, out_off_q} & (out_size_q - SIZE_W'(1))) == '0)
  `BBA_ASSERT_IMPLIES(a_fail_zero, out_valid_q && out_st_q != ST_DONE,
                      out_off_q == '0 && out_size_q == '0)
  `BBA_ASSERT_IMPLIES(a_wr_in_tree, cmd_i.wr_en, waddr < NODE_W'(NODE_COUNT))
  `BBA_ASSERT_NEXT(a_out_held, out_valid_q && !out_ready_i, out_valid_q && $stable(out_st_q))

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// Buddy allocator over a 1024-unit pool with 32-unit minimum blocks. One request is
// worked at a time; its result sits in an output register while the next request is
// taken. The 63 node states live in a one-write, one-read memory with a registered
// read, so every node visit of the walk is a read state followed by an evaluate state.
// An allocate inspects nodes on the way down, splits a free block that is too large and
// steps back up the tree from a subtree with no fit; an oversized request is refused
// without a walk. A free walks down by offset to its block and releases it; the
// release then merges the freed block with its free buddy level by level. A new result
// waits in S_DONE while the previous one is still held in the output register.
// Per-entry valid bits give the reset state at once: no clearing pass.
module buddy_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [10:0] request_size_i,
  input  logic [9:0]  free_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  block_offset_o,
  output logic [10:0] block_size_o
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .free_offset_i  (free_offset_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .block_offset_o (block_offset_o),
    .block_size_o   (block_size_o)
  );

endmodule
